// File: design/assert_macros.svh
// Assertion macros used by the run-length decoder sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define BRU_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define BRU_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error(msg);

`endif

// File: design/bru_pkg.sv
// Shared types and constants of the ByteRun1 run-length decoder.
`timescale 1ns / 1ps
`default_nettype none

package bru_pkg;

	localparam int          SIZE_W         = 13;
	localparam logic [12:0] SIZE_RESET     = 13'd4096;
	localparam int          MAX_OUTPUT_DEF = 4096;
	localparam logic [7:0]  CTRL_SKIP      = 8'h80;

	typedef enum logic {
		S_IDLE,
		S_EVAL
	} state_t;

	typedef enum logic [1:0] {
		PH_CTRL,
		PH_LIT,
		PH_RUN
	} phase_t;

	typedef enum logic [1:0] {
		ST_DEC,
		ST_OK,
		ST_ERR
	} status_t;

	typedef struct packed {
		logic gt;
		logic ge;
	} alu_flags_t;

endpackage

`default_nettype wire

// File: design/bru_alu.sv
// Shared adder and size comparator of the decoder.
`timescale 1ns / 1ps
`default_nettype none

module bru_alu #(
	parameter int MAX_OUTPUT = bru_pkg::MAX_OUTPUT_DEF
) (
	input  wire logic [$clog2(MAX_OUTPUT + 1) - 1:0]                       produced,
	input  wire logic [7:0]                                                addend,
	input  wire logic [$clog2(MAX_OUTPUT + 1) - 1:0]                       size,
	output      logic [(($clog2(MAX_OUTPUT + 1) > 8) ? $clog2(MAX_OUTPUT + 1) : 8):0] sum,
	output      bru_pkg::alu_flags_t                                       flags
);

	localparam int PW = $clog2(MAX_OUTPUT + 1);
	localparam int SW = ((PW > 8) ? PW : 8) + 1;

	logic [SW-1:0] size_ext;

	assign size_ext = SW'(size);
	assign sum      = SW'(produced) + SW'(addend);
	assign flags.gt = (sum > size_ext);
	assign flags.ge = (sum >= size_ext);

endmodule

`default_nettype wire

// File: design/bru_ctrl.sv
// Decode sequencer: block state, per-byte steps and the result register.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module bru_ctrl #(
	parameter int MAX_OUTPUT = bru_pkg::MAX_OUTPUT_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output      logic                                in_ready,
	input  wire logic [7:0]                          in_byte,
	input  wire logic                                end_of_source,
	output      logic                                out_valid,
	input  wire logic                                out_ready,
	output      logic [7:0]                          out_byte_first,
	output      logic [7:0]                          out_byte_second,
	output      logic [1:0]                          byte_count,
	output      logic [1:0]                          status,
	output      logic                                last_of_run,
	output      logic [$clog2(MAX_OUTPUT + 1) - 1:0] produced,
	output      logic [7:0]                          addend,
	input  wire logic [(($clog2(MAX_OUTPUT + 1) > 8) ? $clog2(MAX_OUTPUT + 1) : 8):0] sum,
	input  wire bru_pkg::alu_flags_t                 flags
);

	localparam int PW = $clog2(MAX_OUTPUT + 1);

	bru_pkg::state_t  state_q, state_d;
	bru_pkg::phase_t  phase_q, phase_d;
	logic [7:0]       pending_q, pending_d;
	logic [PW-1:0]    produced_q, produced_d;
	logic             finished_q, finished_d;
	logic [7:0]       byte_q;
	logic             eos_q;

	logic             out_valid_q;
	logic [7:0]       out_first_q, out_second_q;
	logic [1:0]       out_count_q;
	bru_pkg::status_t out_status_q;
	logic             out_last_q;

	logic             need_push, slot_free, push_fire;
	logic [7:0]       push_first, push_second;
	logic [1:0]       push_count;
	bru_pkg::status_t push_status, done_status;
	logic             push_last;

	logic [7:0]       rem;
	logic             run_two, run_last, ctrl_skip, ctrl_err;

	assign in_ready  = (state_q == bru_pkg::S_IDLE);
	assign slot_free = !out_valid_q || out_ready;
	assign push_fire = need_push && slot_free;
	assign produced  = produced_q;

	assign rem       = (pending_q == 8'd0) ? 8'd1 : pending_q;
	assign run_two   = (rem >= 8'd2);
	assign run_last  = (rem <= 8'd2);
	assign ctrl_skip = (byte_q == bru_pkg::CTRL_SKIP);
	assign ctrl_err  = !ctrl_skip && flags.gt;

	// Status once the byte ends its work: reached size, early end, or still going.
	assign done_status = flags.ge ? bru_pkg::ST_OK :
	                     (eos_q ? bru_pkg::ST_ERR : bru_pkg::ST_DEC);

	always_comb begin
		unique case (phase_q)
			bru_pkg::PH_LIT: addend = 8'd1;
			bru_pkg::PH_RUN: addend = run_two ? 8'd2 : 8'd1;
			default: begin
				if (!byte_q[7]) begin
					addend = byte_q + 8'd1;
				end else begin
					addend = 8'(9'd257 - {1'b0, byte_q});
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= bru_pkg::S_IDLE;
			phase_q    <= bru_pkg::PH_CTRL;
			pending_q  <= 8'd0;
			produced_q <= '0;
			finished_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			phase_q    <= phase_d;
			pending_q  <= pending_d;
			produced_q <= produced_d;
			finished_q <= finished_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_q <= in_byte;
			eos_q  <= end_of_source;
		end
	end

	always_comb begin
		state_d     = state_q;
		phase_d     = phase_q;
		pending_d   = pending_q;
		produced_d  = produced_q;
		finished_d  = finished_q;
		need_push   = 1'b0;
		push_first  = 8'd0;
		push_second = 8'd0;
		push_count  = 2'd0;
		push_status = bru_pkg::ST_DEC;
		push_last   = 1'b0;

		unique case (state_q)
			bru_pkg::S_IDLE: begin
				if (in_valid) begin
					state_d = bru_pkg::S_EVAL;
				end
			end
			bru_pkg::S_EVAL: begin
				if (finished_q) begin
					// Drop bytes of a done block; the end mark re-arms it.
					if (eos_q) begin
						phase_d    = bru_pkg::PH_CTRL;
						pending_d  = 8'd0;
						produced_d = '0;
						finished_d = 1'b0;
					end
					state_d = bru_pkg::S_IDLE;
				end else begin
					unique case (phase_q)
						bru_pkg::PH_LIT: begin
							need_push   = 1'b1;
							push_first  = byte_q;
							push_count  = 2'd1;
							push_status = done_status;
							push_last   = 1'b1;
						end
						bru_pkg::PH_RUN: begin
							need_push   = 1'b1;
							push_first  = byte_q;
							push_second = run_two ? byte_q : 8'd0;
							push_count  = run_two ? 2'd2 : 2'd1;
							push_status = run_last ? done_status : bru_pkg::ST_DEC;
							push_last   = run_last;
						end
						default: begin
							need_push   = ctrl_err || eos_q;
							push_status = bru_pkg::ST_ERR;
							push_last   = 1'b1;
						end
					endcase

					// Hold everything while a result is due and the result register is still full.
					if (!need_push || slot_free) begin
						unique case (phase_q)
							bru_pkg::PH_LIT: begin
								produced_d = PW'(sum);
								pending_d  = (pending_q != 8'd0) ? pending_q - 8'd1 : 8'd0;
								if (pending_d == 8'd0) begin
									phase_d = bru_pkg::PH_CTRL;
								end
								state_d = bru_pkg::S_IDLE;
							end
							bru_pkg::PH_RUN: begin
								produced_d = PW'(sum);
								pending_d  = rem - addend;
								if (run_last) begin
									pending_d = 8'd0;
									phase_d   = bru_pkg::PH_CTRL;
									state_d   = bru_pkg::S_IDLE;
								end
							end
							default: begin
								if (!ctrl_err && !ctrl_skip) begin
									phase_d   = byte_q[7] ? bru_pkg::PH_RUN : bru_pkg::PH_LIT;
									pending_d = addend;
								end
								state_d = bru_pkg::S_IDLE;
							end
						endcase

						if (need_push && push_last && push_status != bru_pkg::ST_DEC) begin
							finished_d = 1'b1;
							if (eos_q) begin
								phase_d    = bru_pkg::PH_CTRL;
								pending_d  = 8'd0;
								produced_d = '0;
								finished_d = 1'b0;
							end
						end
					end
				end
			end
			default: state_d = bru_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push_fire) begin
			out_first_q  <= push_first;
			out_second_q <= push_second;
			out_count_q  <= push_count;
			out_status_q <= push_status;
			out_last_q   <= push_last;
		end
	end

	assign out_valid       = out_valid_q;
	assign out_byte_first  = out_first_q;
	assign out_byte_second = out_second_q;
	assign byte_count      = out_count_q;
	assign status          = out_status_q;
	assign last_of_run     = out_last_q;

	`BRU_ASSERT_NEVER(a_status_only_last, clk, arst_n,
		out_valid_q && (out_status_q != bru_pkg::ST_DEC) && !out_last_q,
		"final status on a result that is not the last of its byte")
	`BRU_ASSERT_NEVER(a_empty_is_error, clk, arst_n,
		out_valid_q && (out_count_q == 2'd0) && (out_status_q != bru_pkg::ST_ERR),
		"empty result without error status")
	`BRU_ASSERT_NEVER(a_pending_range, clk, arst_n,
		pending_q > 8'd128,
		"pending count beyond the longest run")
	`BRU_ASSERT(a_eval_entry, clk, arst_n,
		(state_q == bru_pkg::S_EVAL) |-> $past((state_q == bru_pkg::S_EVAL) || (in_valid && in_ready)),
		"sequencer busy without an accepted byte")

endmodule

`default_nettype wire

// File: design/byterun1_run_length_decoder.sv
// Top level of the ByteRun1 run-length decoder: size register and datapath.
//
//  channel   direction  handshake              payload
//  in        sink       in_valid / in_ready    in_byte, end_of_source
//  out       source     out_valid / out_ready  out_byte_first, out_byte_second,
//                                              byte_count, status, last_of_run
//  cfg       sink       cfg_valid / cfg_ready  cfg_data (expected_size)
//
// A literal byte or a control byte is transferred in, then handled in the sequencer.
// A run byte of n repeats is transferred in; then the shared adder emits one result,
// up to two bytes, per cycle while the result register can take it.
// Reset clears the control state and out_valid at once; expected_size returns to 4096. No clearing pass.
// While the result register is full and out_ready is low the sequencer holds a byte that must push a result.
// A result may wait in the output register while the next byte transfers in.
`timescale 1ns / 1ps
`default_nettype none

module byterun1_run_length_decoder #(
	parameter int MAX_OUTPUT = bru_pkg::MAX_OUTPUT_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output      logic        in_ready,
	input  wire logic [7:0]  in_byte,
	input  wire logic        end_of_source,
	output      logic        out_valid,
	input  wire logic        out_ready,
	output      logic [7:0]  out_byte_first,
	output      logic [7:0]  out_byte_second,
	output      logic [1:0]  byte_count,
	output      logic [1:0]  status,
	output      logic        last_of_run,
	input  wire logic        cfg_valid,
	output      logic        cfg_ready,
	input  wire logic [12:0] cfg_data
);

	localparam int PW = $clog2(MAX_OUTPUT + 1);
	localparam int SW = ((PW > 8) ? PW : 8) + 1;
	localparam int EW = (PW > bru_pkg::SIZE_W) ? PW : bru_pkg::SIZE_W;

	logic [12:0]         expected_size_q;
	logic [EW-1:0]       size_ext;
	logic [PW-1:0]       size_eff;
	logic [PW-1:0]       produced;
	logic [7:0]          addend;
	logic [SW-1:0]       sum;
	bru_pkg::alu_flags_t flags;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_size_q <= bru_pkg::SIZE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			expected_size_q <= cfg_data;
		end
	end

	// Clamp the programmed size to 1..MAX_OUTPUT.
	assign size_ext = EW'(expected_size_q);
	always_comb begin
		if (size_ext == '0) begin
			size_eff = PW'(1);
		end else if (size_ext > EW'(MAX_OUTPUT)) begin
			size_eff = PW'(MAX_OUTPUT);
		end else begin
			size_eff = PW'(size_ext);
		end
	end

	bru_ctrl #(
		.MAX_OUTPUT(MAX_OUTPUT)
	) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.in_byte        (in_byte),
		.end_of_source  (end_of_source),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_byte_first (out_byte_first),
		.out_byte_second(out_byte_second),
		.byte_count     (byte_count),
		.status         (status),
		.last_of_run    (last_of_run),
		.produced       (produced),
		.addend         (addend),
		.sum            (sum),
		.flags          (flags)
	);

	bru_alu #(
		.MAX_OUTPUT(MAX_OUTPUT)
	) u_alu (
		.produced(produced),
		.addend  (addend),
		.size    (size_eff),
		.sum     (sum),
		.flags   (flags)
	);

endmodule

`default_nettype wire
